### src/round_robin_task_scheduler_macros.svh
// Assertion macros shared by the scheduler RTL.
// Each macro expects clk and rst_n in scope.
`ifndef ROUND_ROBIN_TASK_SCHEDULER_MACROS_SVH
`define ROUND_ROBIN_TASK_SCHEDULER_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define RRTS_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Condition must hold at every sampled edge outside reset.
`define RRTS_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error(msg);

`endif

### src/rrts_pkg.sv
`default_nettype none

package rrts_pkg;

  localparam int NUM_SLOTS = 32;
  localparam int SLOT_W    = $clog2(NUM_SLOTS);
  localparam int CNT_W     = $clog2(NUM_SLOTS + 1);
  localparam int SLOT_FW   = 5;
  localparam int PRIO_W    = 8;

  localparam logic [1:0] MODE_ALLOC  = 2'd0;
  localparam logic [1:0] MODE_RUN    = 2'd1;
  localparam logic [1:0] MODE_SLEEP  = 2'd2;
  localparam logic [1:0] MODE_SWITCH = 2'd3;

  localparam logic [1:0] STS_OK      = 2'd0;
  localparam logic [1:0] STS_NOFREE  = 2'd1;
  localparam logic [1:0] STS_IGNORED = 2'd2;
  localparam logic [1:0] STS_EMPTY   = 2'd3;

  typedef struct packed {
    logic [1:0]         mode;
    logic [SLOT_FW-1:0] slot;
    logic [PRIO_W-1:0]  priority_req;
  } in_item_t;

  typedef struct packed {
    logic [1:0]         status;
    logic [SLOT_FW-1:0] chosen_slot;
    logic               do_switch;
    logic [PRIO_W-1:0]  time_slice;
  } out_item_t;

  // Datapath operations requested by the controller
  typedef enum logic [4:0] {
    OP_IDLE,
    OP_RUN,
    OP_IGNORE,
    OP_EMPTY,
    OP_NOFREE,
    OP_ALLOC_START,
    OP_ALLOC_TAKE,
    OP_ALLOC_NEXT,
    OP_SLEEP_START,
    OP_SEARCH,
    OP_SHIFT_START,
    OP_SHIFT,
    OP_SHIFT_END,
    OP_FIX_BEFORE,
    OP_FIX_AT,
    OP_FIX_AFTER,
    OP_SW_PREV,
    OP_SW_ADV,
    OP_FIN_LIST,
    OP_FIN_PRIO,
    OP_FIN_EMIT
  } op_t;

  typedef struct packed {
    op_t op;
  } cmd_t;

  typedef struct packed {
    logic run_ok;     // run request carries a usable slot and priority
    logic slot_run;   // requested slot is in range and runnable
    logic cnt_zero;   // run list empty
    logic free_hit;   // slot under the scan index is free
    logic idx_last;   // scan index on the last slot
    logic match_hit;  // list entry just read equals the sleeping slot
    logic scan_end;   // list walk finished, nothing in flight
    logic pos_lt_cur; // removed entry stood before the current position
    logic pos_eq_cur; // removed entry was the current one
  } stat_t;

endpackage

`default_nettype wire

### src/rrts_ram.sv
`default_nettype none

module rrts_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    rd_data_r <= mem_r[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

### src/rrts_ctrl.sv
`default_nettype none

module rrts_ctrl (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           start,
  input  wire logic [1:0]     in_mode,
  input  wire rrts_pkg::stat_t st,
  output rrts_pkg::cmd_t      cmd,
  output logic                busy
);

  typedef enum logic [9:0] {
    S_IDLE     = 10'b00_0000_0001,
    S_ALLOC    = 10'b00_0000_0010,
    S_SEARCH   = 10'b00_0000_0100,
    S_SHIFT    = 10'b00_0000_1000,
    S_FIX      = 10'b00_0001_0000,
    S_SW_ADV   = 10'b00_0010_0000,
    S_FIN_LIST = 10'b00_0100_0000,
    S_FIN_PRIO = 10'b00_1000_0000,
    S_FIN_EMIT = 10'b01_0000_0000,
    S_SPARE    = 10'b10_0000_0000
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd.op    = rrts_pkg::OP_IDLE;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          case (in_mode)
            rrts_pkg::MODE_ALLOC: begin
              cmd.op    = rrts_pkg::OP_ALLOC_START;
              state_nxt = S_ALLOC;
            end
            rrts_pkg::MODE_RUN: begin
              cmd.op = st.run_ok ? rrts_pkg::OP_RUN : rrts_pkg::OP_IGNORE;
            end
            rrts_pkg::MODE_SLEEP: begin
              if (st.slot_run) begin
                cmd.op    = rrts_pkg::OP_SLEEP_START;
                state_nxt = S_SEARCH;
              end else begin
                cmd.op = rrts_pkg::OP_IGNORE;
              end
            end
            default: begin
              if (st.cnt_zero) begin
                cmd.op = rrts_pkg::OP_EMPTY;
              end else begin
                cmd.op    = rrts_pkg::OP_SW_PREV;
                state_nxt = S_SW_ADV;
              end
            end
          endcase
        end
      end
      S_ALLOC: begin
        if (st.free_hit) begin
          cmd.op    = rrts_pkg::OP_ALLOC_TAKE;
          state_nxt = S_IDLE;
        end else if (st.idx_last) begin
          cmd.op    = rrts_pkg::OP_NOFREE;
          state_nxt = S_IDLE;
        end else begin
          cmd.op = rrts_pkg::OP_ALLOC_NEXT;
        end
      end
      S_SEARCH: begin
        if (st.match_hit) begin
          cmd.op    = rrts_pkg::OP_SHIFT_START;
          state_nxt = S_SHIFT;
        end else if (st.scan_end) begin
          cmd.op    = rrts_pkg::OP_IGNORE;
          state_nxt = S_IDLE;
        end else begin
          cmd.op = rrts_pkg::OP_SEARCH;
        end
      end
      S_SHIFT: begin
        if (st.scan_end) begin
          cmd.op    = rrts_pkg::OP_SHIFT_END;
          state_nxt = S_FIX;
        end else begin
          cmd.op = rrts_pkg::OP_SHIFT;
        end
      end
      S_FIX: begin
        if (st.cnt_zero) begin
          cmd.op    = rrts_pkg::OP_EMPTY;
          state_nxt = S_IDLE;
        end else begin
          if (st.pos_lt_cur) begin
            cmd.op = rrts_pkg::OP_FIX_BEFORE;
          end else if (st.pos_eq_cur) begin
            cmd.op = rrts_pkg::OP_FIX_AT;
          end else begin
            cmd.op = rrts_pkg::OP_FIX_AFTER;
          end
          state_nxt = S_FIN_LIST;
        end
      end
      S_SW_ADV: begin
        cmd.op    = rrts_pkg::OP_SW_ADV;
        state_nxt = S_FIN_LIST;
      end
      S_FIN_LIST: begin
        cmd.op    = rrts_pkg::OP_FIN_LIST;
        state_nxt = S_FIN_PRIO;
      end
      S_FIN_PRIO: begin
        cmd.op    = rrts_pkg::OP_FIN_PRIO;
        state_nxt = S_FIN_EMIT;
      end
      S_FIN_EMIT: begin
        cmd.op    = rrts_pkg::OP_FIN_EMIT;
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy = (state_r != S_IDLE);

endmodule

`default_nettype wire

### src/rrts_dp.sv
`default_nettype none

`include "round_robin_task_scheduler_macros.svh"

module rrts_dp (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire rrts_pkg::in_item_t in_data,
  input  wire rrts_pkg::cmd_t     cmd,
  output rrts_pkg::stat_t         st,
  output logic                    out_valid,
  output rrts_pkg::out_item_t     out_data
);

  typedef enum logic [1:0] {
    SWK_NONE,
    SWK_FORCE,
    SWK_CMP
  } swk_t;

  // slot state: free is neither bit set
  logic [rrts_pkg::NUM_SLOTS-1:0] run_mask_r, run_mask_nxt;
  logic [rrts_pkg::NUM_SLOTS-1:0] alloc_mask_r, alloc_mask_nxt;
  logic [rrts_pkg::CNT_W-1:0]     cnt_r, cnt_nxt;
  logic [rrts_pkg::SLOT_W-1:0]    cur_r, cur_nxt;
  logic [rrts_pkg::CNT_W-1:0]     idx_r, idx_nxt;
  logic [rrts_pkg::SLOT_W-1:0]    tag_r, tag_nxt;
  logic                           rd_vld_r, rd_vld_nxt;
  logic [rrts_pkg::SLOT_W-1:0]    pos_r, pos_nxt;
  logic [rrts_pkg::SLOT_W-1:0]    slot_r, slot_nxt;
  logic [rrts_pkg::SLOT_W-1:0]    prev_r, prev_nxt;
  logic [rrts_pkg::SLOT_W-1:0]    sel_r, sel_nxt;
  swk_t                           swk_r, swk_nxt;
  logic                           out_valid_r, out_valid_nxt;
  rrts_pkg::out_item_t            out_data_r, out_data_nxt;

  logic                           lst_we;
  logic [rrts_pkg::SLOT_W-1:0]    lst_waddr, lst_wdata, lst_raddr, lst_rdata;
  logic                           pr_we;
  logic [rrts_pkg::SLOT_W-1:0]    pr_waddr, pr_raddr;
  logic [rrts_pkg::PRIO_W-1:0]    pr_wdata, pr_rdata;

  logic [rrts_pkg::SLOT_W-1:0]    in_slot;
  logic [rrts_pkg::SLOT_W-1:0]    idx_slot;
  logic [rrts_pkg::CNT_W-1:0]     cur_inc;
  logic                           slot_ok;
  logic                           slot_run;
  logic                           issue;
  logic                           append;

  rrts_ram #(
    .WIDTH (rrts_pkg::SLOT_W),
    .DEPTH (rrts_pkg::NUM_SLOTS)
  ) u_list_ram (
    .clk     (clk),
    .wr_en   (lst_we),
    .wr_addr (lst_waddr),
    .wr_data (lst_wdata),
    .rd_addr (lst_raddr),
    .rd_data (lst_rdata)
  );

  rrts_ram #(
    .WIDTH (rrts_pkg::PRIO_W),
    .DEPTH (rrts_pkg::NUM_SLOTS)
  ) u_prio_ram (
    .clk     (clk),
    .wr_en   (pr_we),
    .wr_addr (pr_waddr),
    .wr_data (pr_wdata),
    .rd_addr (pr_raddr),
    .rd_data (pr_rdata)
  );

  assign in_slot  = rrts_pkg::SLOT_W'(in_data.slot);
  assign idx_slot = idx_r[rrts_pkg::SLOT_W-1:0];
  assign slot_ok  = (int'(in_data.slot) < rrts_pkg::NUM_SLOTS);
  assign slot_run = slot_ok && run_mask_r[in_slot];
  assign issue    = (idx_r < cnt_r);
  assign append   = !slot_run && (int'(cnt_r) < rrts_pkg::NUM_SLOTS);
  assign cur_inc  = rrts_pkg::CNT_W'(cur_r) + rrts_pkg::CNT_W'(1);

  always_comb begin
    st.run_ok     = slot_ok && (in_data.priority_req != '0);
    st.slot_run   = slot_run;
    st.cnt_zero   = (cnt_r == '0);
    st.free_hit   = !run_mask_r[idx_slot] && !alloc_mask_r[idx_slot];
    st.idx_last   = (idx_r == rrts_pkg::CNT_W'(rrts_pkg::NUM_SLOTS - 1));
    st.match_hit  = rd_vld_r && (lst_rdata == slot_r);
    st.scan_end   = !issue && !rd_vld_r;
    st.pos_lt_cur = (pos_r < cur_r);
    st.pos_eq_cur = (pos_r == cur_r);
  end

  always_comb begin
    run_mask_nxt   = run_mask_r;
    alloc_mask_nxt = alloc_mask_r;
    cnt_nxt        = cnt_r;
    cur_nxt        = cur_r;
    idx_nxt        = idx_r;
    tag_nxt        = tag_r;
    rd_vld_nxt     = rd_vld_r;
    pos_nxt        = pos_r;
    slot_nxt       = slot_r;
    prev_nxt       = prev_r;
    sel_nxt        = sel_r;
    swk_nxt        = swk_r;
    out_valid_nxt  = 1'b0;
    out_data_nxt   = out_data_r;
    lst_we         = 1'b0;
    lst_waddr      = cnt_r[rrts_pkg::SLOT_W-1:0];
    lst_wdata      = in_slot;
    lst_raddr      = cur_r;
    pr_we          = 1'b0;
    pr_waddr       = in_slot;
    pr_wdata       = in_data.priority_req;
    pr_raddr       = lst_rdata;

    case (cmd.op)
      rrts_pkg::OP_RUN: begin
        pr_we = 1'b1;
        if (append) begin
          lst_we                  = 1'b1;
          run_mask_nxt[in_slot]   = 1'b1;
          alloc_mask_nxt[in_slot] = 1'b0;
          cnt_nxt                 = cnt_r + rrts_pkg::CNT_W'(1);
        end
        out_valid_nxt = 1'b1;
        out_data_nxt  = '{rrts_pkg::STS_OK, in_data.slot, 1'b0, in_data.priority_req};
      end
      rrts_pkg::OP_IGNORE: begin
        out_valid_nxt = 1'b1;
        out_data_nxt  = '{rrts_pkg::STS_IGNORED, '0, 1'b0, '0};
      end
      rrts_pkg::OP_EMPTY: begin
        cur_nxt       = '0;
        out_valid_nxt = 1'b1;
        out_data_nxt  = '{rrts_pkg::STS_EMPTY, '0, 1'b0, '0};
      end
      rrts_pkg::OP_NOFREE: begin
        out_valid_nxt = 1'b1;
        out_data_nxt  = '{rrts_pkg::STS_NOFREE, '0, 1'b0, '0};
      end
      rrts_pkg::OP_ALLOC_START: begin
        idx_nxt = '0;
      end
      rrts_pkg::OP_ALLOC_TAKE: begin
        alloc_mask_nxt[idx_slot] = 1'b1;
        out_valid_nxt            = 1'b1;
        out_data_nxt = '{rrts_pkg::STS_OK, rrts_pkg::SLOT_FW'(idx_slot), 1'b0, '0};
      end
      rrts_pkg::OP_ALLOC_NEXT: begin
        idx_nxt = idx_r + rrts_pkg::CNT_W'(1);
      end
      rrts_pkg::OP_SLEEP_START: begin
        run_mask_nxt[in_slot]   = 1'b0;
        alloc_mask_nxt[in_slot] = 1'b1;
        slot_nxt                = in_slot;
        idx_nxt                 = '0;
        rd_vld_nxt              = 1'b0;
      end
      rrts_pkg::OP_SEARCH: begin
        lst_raddr  = idx_slot;
        rd_vld_nxt = issue;
        tag_nxt    = idx_slot;
        if (issue) begin
          idx_nxt = idx_r + rrts_pkg::CNT_W'(1);
        end
      end
      rrts_pkg::OP_SHIFT_START: begin
        pos_nxt    = tag_r;
        idx_nxt    = rrts_pkg::CNT_W'(tag_r) + rrts_pkg::CNT_W'(1);
        rd_vld_nxt = 1'b0;
      end
      rrts_pkg::OP_SHIFT: begin
        // move the entry read last cycle one place towards the head
        if (rd_vld_r) begin
          lst_we    = 1'b1;
          lst_waddr = tag_r - rrts_pkg::SLOT_W'(1);
          lst_wdata = lst_rdata;
        end
        lst_raddr  = idx_slot;
        rd_vld_nxt = issue;
        tag_nxt    = idx_slot;
        if (issue) begin
          idx_nxt = idx_r + rrts_pkg::CNT_W'(1);
        end
      end
      rrts_pkg::OP_SHIFT_END: begin
        cnt_nxt = cnt_r - rrts_pkg::CNT_W'(1);
      end
      rrts_pkg::OP_FIX_BEFORE: begin
        cur_nxt = cur_r - rrts_pkg::SLOT_W'(1);
        swk_nxt = SWK_NONE;
      end
      rrts_pkg::OP_FIX_AT: begin
        if (rrts_pkg::CNT_W'(cur_r) >= cnt_r) begin
          cur_nxt = '0;
        end
        swk_nxt = SWK_FORCE;
      end
      rrts_pkg::OP_FIX_AFTER: begin
        swk_nxt = SWK_NONE;
      end
      rrts_pkg::OP_SW_PREV: begin
        lst_raddr = cur_r;
      end
      rrts_pkg::OP_SW_ADV: begin
        prev_nxt = lst_rdata;
        cur_nxt  = (cur_inc >= cnt_r) ? '0 : cur_inc[rrts_pkg::SLOT_W-1:0];
        swk_nxt  = SWK_CMP;
      end
      rrts_pkg::OP_FIN_LIST: begin
        lst_raddr = cur_r;
      end
      rrts_pkg::OP_FIN_PRIO: begin
        sel_nxt  = lst_rdata;
        pr_raddr = lst_rdata;
      end
      rrts_pkg::OP_FIN_EMIT: begin
        out_valid_nxt            = 1'b1;
        out_data_nxt.status      = rrts_pkg::STS_OK;
        out_data_nxt.chosen_slot = rrts_pkg::SLOT_FW'(sel_r);
        out_data_nxt.time_slice  = pr_rdata;
        case (swk_r)
          SWK_FORCE: out_data_nxt.do_switch = 1'b1;
          SWK_CMP:   out_data_nxt.do_switch = (sel_r != prev_r);
          default:   out_data_nxt.do_switch = 1'b0;
        endcase
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_mask_r   <= '0;
      alloc_mask_r <= '0;
      cnt_r        <= '0;
      cur_r        <= '0;
      idx_r        <= '0;
      rd_vld_r     <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      run_mask_r   <= run_mask_nxt;
      alloc_mask_r <= alloc_mask_nxt;
      cnt_r        <= cnt_nxt;
      cur_r        <= cur_nxt;
      idx_r        <= idx_nxt;
      rd_vld_r     <= rd_vld_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    tag_r      <= tag_nxt;
    pos_r      <= pos_nxt;
    slot_r     <= slot_nxt;
    prev_r     <= prev_nxt;
    sel_r      <= sel_nxt;
    swk_r      <= swk_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  `RRTS_ASSERT_ALWAYS(a_mask_excl, (run_mask_r & alloc_mask_r) == '0, "slot both allocated and runnable")
  `RRTS_ASSERT_IMP(a_cnt_pop, cmd.op == rrts_pkg::OP_IDLE, $countones(run_mask_r) == int'(cnt_r), "run count differs from runnable slots")
  `RRTS_ASSERT_IMP(a_cur_range, cmd.op == rrts_pkg::OP_IDLE, (cnt_r == '0) ? (cur_r == '0) : (rrts_pkg::CNT_W'(cur_r) < cnt_r), "current position outside run list")
  `RRTS_ASSERT_IMP(a_shift_tag, (cmd.op == rrts_pkg::OP_SHIFT) && rd_vld_r, tag_r != '0, "compaction write below list head")

endmodule

`default_nettype wire

### src/round_robin_task_scheduler.sv
// Round-robin task scheduler over rrts_pkg::NUM_SLOTS task slots.
// Input channel: present in_data (mode, slot, priority_req) with start high;
// the transfer happens on the rising edge where start is high and busy low.
// Result channel: out_valid strobes for exactly one cycle with out_data
// (status, chosen_slot, do_switch, time_slice); the receiver cannot stall,
// so every result must be taken on that cycle. Exactly one result per item.
// From the accepting edge to the strobe:
//   run, ignored request, switch on an empty list: registered (back to back)
//   allocate: the slot-state scan tests one slot per cycle from slot 0 to the
//     lowest free slot, or to the last slot when none is free
//   switch: three reads of the list and priority RAMs in turn
//   sleep: one list RAM port walks the list to find the entry, then moves
//     each later entry up one place
// busy falls on the cycle the result strobes, so the next item can follow.
// Reset (rst_n low, synchronous) marks every slot free and empties the run
// list; the list and priority RAMs are not cleared and need no sweep.
`default_nettype none

module round_robin_task_scheduler (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  input  wire rrts_pkg::in_item_t in_data,
  output logic                    busy,
  output logic                    out_valid,
  output rrts_pkg::out_item_t     out_data
);

  // command and status between the sequencer and the slot datapath
  rrts_pkg::cmd_t  cmd;
  rrts_pkg::stat_t st;

  // sequencer: decode the accepted mode, then step through scan, list walk
  // and result assembly
  rrts_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (start),
    .in_mode (in_data.mode),
    .st      (st),
    .cmd     (cmd),
    .busy    (busy)
  );

  // datapath: slot state, run count, current position, list and priority
  // RAMs, and the registered result
  rrts_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cmd       (cmd),
    .st        (st),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire

### tb/tb.sv
class sched_scoreboard;
  typedef enum logic [1:0] {SLOT_FREE, SLOT_ALLOC, SLOT_RUN} slot_state_t;

  slot_state_t        slot_state [rrts_pkg::NUM_SLOTS];
  logic [7:0]         slot_prio  [rrts_pkg::NUM_SLOTS];
  logic [4:0]         run_order  [rrts_pkg::NUM_SLOTS];
  int                 run_cnt;
  int                 cur_pos;
  rrts_pkg::out_item_t outstanding[$];
  int                 errors;

  function new();
    foreach (slot_state[i]) begin
      slot_state[i] = SLOT_FREE;
      slot_prio[i]  = '0;
      run_order[i]  = '0;
    end
    run_cnt = 0;
    cur_pos = 0;
    errors  = 0;
  endfunction

  function int pending();
    return outstanding.size();
  endfunction

  // Random slot from the run list; any slot when the list is empty.
  function logic [4:0] pick_runnable();
    if (run_cnt == 0) return 5'($urandom_range(0, rrts_pkg::NUM_SLOTS - 1));
    return run_order[$urandom_range(0, run_cnt - 1)];
  endfunction

  function rrts_pkg::out_item_t schedule_step(rrts_pkg::in_item_t req);
    rrts_pkg::out_item_t res;
    int                  hole;
    logic [4:0]          prev_slot;
    logic [4:0]          next_slot;
    res  = '0;
    hole = run_cnt;
    case (req.mode)
      rrts_pkg::MODE_ALLOC: begin
        res.status = rrts_pkg::STS_NOFREE;
        for (int i = 0; i < rrts_pkg::NUM_SLOTS; i++) begin
          if (slot_state[i] == SLOT_FREE) begin
            slot_state[i]   = SLOT_ALLOC;
            res.status      = rrts_pkg::STS_OK;
            res.chosen_slot = 5'(i);
            break;
          end
        end
      end
      rrts_pkg::MODE_RUN: begin
        if (req.priority_req == '0) begin
          res.status = rrts_pkg::STS_IGNORED;
        end else begin
          slot_prio[req.slot] = req.priority_req;
          if (slot_state[req.slot] != SLOT_RUN && run_cnt < rrts_pkg::NUM_SLOTS) begin
            run_order[run_cnt]   = req.slot;
            run_cnt++;
            slot_state[req.slot] = SLOT_RUN;
          end
          res.status      = rrts_pkg::STS_OK;
          res.chosen_slot = req.slot;
          res.time_slice  = req.priority_req;
        end
      end
      rrts_pkg::MODE_SLEEP: begin
        if (slot_state[req.slot] == SLOT_RUN) begin
          slot_state[req.slot] = SLOT_ALLOC;
          for (int i = 0; i < run_cnt; i++) begin
            if (run_order[i] == req.slot) begin
              hole = i;
              break;
            end
          end
        end
        if (hole >= run_cnt) begin
          res.status = rrts_pkg::STS_IGNORED;
        end else begin
          for (int i = hole; i + 1 < run_cnt; i++) run_order[i] = run_order[i + 1];
          run_cnt--;
          if (run_cnt == 0) begin
            cur_pos    = 0;
            res.status = rrts_pkg::STS_EMPTY;
          end else begin
            if (hole < cur_pos) begin
              cur_pos--;
            end else if (hole == cur_pos) begin
              res.do_switch = 1'b1;
              if (cur_pos >= run_cnt) cur_pos = 0;
            end
            next_slot       = run_order[cur_pos];
            res.status      = rrts_pkg::STS_OK;
            res.chosen_slot = next_slot;
            res.time_slice  = slot_prio[next_slot];
          end
        end
      end
      default: begin
        if (run_cnt == 0) begin
          cur_pos    = 0;
          res.status = rrts_pkg::STS_EMPTY;
        end else begin
          prev_slot = run_order[cur_pos];
          cur_pos++;
          if (cur_pos >= run_cnt) cur_pos = 0;
          next_slot       = run_order[cur_pos];
          res.status      = rrts_pkg::STS_OK;
          res.chosen_slot = next_slot;
          res.do_switch   = (next_slot != prev_slot);
          res.time_slice  = slot_prio[next_slot];
        end
      end
    endcase
    return res;
  endfunction

  function void note_request(rrts_pkg::in_item_t req);
    outstanding.push_back(schedule_step(req));
  endfunction

  function void check_result(rrts_pkg::out_item_t got);
    rrts_pkg::out_item_t want;
    if (outstanding.size() == 0) begin
      $error("result with nothing outstanding: %h", got);
      errors++;
      return;
    end
    want = outstanding.pop_front();
    if (got.status !== want.status) begin
      $error("status: expected %0d, actual %0d", want.status, got.status);
      errors++;
    end
    if (got.chosen_slot !== want.chosen_slot) begin
      $error("chosen_slot: expected %0d, actual %0d", want.chosen_slot, got.chosen_slot);
      errors++;
    end
    if (got.do_switch !== want.do_switch) begin
      $error("do_switch: expected %0d, actual %0d", want.do_switch, got.do_switch);
      errors++;
    end
    if (got.time_slice !== want.time_slice) begin
      $error("time_slice: expected %0d, actual %0d", want.time_slice, got.time_slice);
      errors++;
    end
  endfunction
endclass

module tb;

  // Worst correct run is some 720 items, sleeps on a full list the longest;
  // allow more than ten times its length before calling it a hang.
  localparam int CYCLE_LIMIT = 400000;
  // Longest item is a sleep on a full list.
  localparam int TAIL_CYCLES = rrts_pkg::NUM_SLOTS + 16;

  logic                clk;
  logic                rst_n;
  logic                start;
  rrts_pkg::in_item_t  in_data;
  logic                busy;
  logic                out_valid;
  rrts_pkg::out_item_t out_data;

  sched_scoreboard sb = new();
  int unsigned     cycle_count = 0;
  bit              gaps_on;

  round_robin_task_scheduler dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .in_data  (in_data),
    .busy     (busy),
    .out_valid(out_valid),
    .out_data (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Sample both channels on the rising edge: every value read here is the one
  // that stood before the edge, so the result never hangs on event order.
  // Check the result first; a new transfer's prediction goes behind it.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid) sb.check_result(out_data);
      if (start && !busy) sb.note_request(in_data);
    end
  end

  // Watchdog: a stuck busy or a missing result ends up here.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  function automatic rrts_pkg::in_item_t make_req(logic [1:0] mode, int slot, int prio);
    rrts_pkg::in_item_t req;
    req.mode         = mode;
    req.slot         = 5'(slot);
    req.priority_req = 8'(prio);
    return req;
  endfunction

  // Present one request and hold it until the transfer edge. Start is left
  // high on return so the next request can follow back to back; an idle
  // burst, when drawn, drops start first.
  task automatic send_request(rrts_pkg::in_item_t req, bit allow_gaps);
    int gap;
    if (allow_gaps && $urandom_range(0, 3) == 0) begin
      gap   = $urandom_range(1, 6);
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start   <= 1'b1;
    in_data <= req;
    do @(posedge clk); while (busy);
  endtask

  // Hold off new work until every predicted result has been taken. Wait for a
  // clock edge first so the last transfer is already in the scoreboard.
  task automatic drain_results();
    start <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
  endtask

  // Mostly meaningful traffic: sleeps aim at slots on the run list, runs
  // sometimes re-prioritise a runnable slot; the rest is random noise.
  function automatic rrts_pkg::in_item_t random_req(int sleep_pct);
    int roll;
    int prio;
    roll = $urandom_range(0, 99);
    prio = $urandom_range(0, 255);
    if (roll < 8) begin
      return make_req(rrts_pkg::MODE_ALLOC, $urandom_range(0, 31), prio);
    end else if (roll < 8 + sleep_pct) begin
      if ($urandom_range(0, 3) != 0)
        return make_req(rrts_pkg::MODE_SLEEP, sb.pick_runnable(), prio);
      return make_req(rrts_pkg::MODE_SLEEP, $urandom_range(0, 31), prio);
    end else if (roll < 38 + sleep_pct) begin
      return make_req(rrts_pkg::MODE_SWITCH, $urandom_range(0, 31), prio);
    end
    roll = $urandom_range(0, 99);
    if (roll < 6)       prio = 0;
    else if (roll < 11) prio = 255;
    else                prio = $urandom_range(1, 255);
    if ($urandom_range(0, 9) < 3)
      return make_req(rrts_pkg::MODE_RUN, sb.pick_runnable(), prio);
    return make_req(rrts_pkg::MODE_RUN, $urandom_range(0, 31), prio);
  endfunction

  initial begin
    rst_n   <= 1'b0;
    start   <= 1'b0;
    in_data <= '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // Directed opening: empty list, ignored requests, allocation from the
    // bottom, running a free slot directly, re-prioritising a runnable slot,
    // wrap-around on switch, and sleeps before, at and after the current task.
    send_request(make_req(rrts_pkg::MODE_SWITCH, 0, 0), 1'b0);    // empty list
    send_request(make_req(rrts_pkg::MODE_SLEEP, 0, 0), 1'b0);     // not runnable
    send_request(make_req(rrts_pkg::MODE_ALLOC, 31, 255), 1'b0);  // slot 0
    send_request(make_req(rrts_pkg::MODE_ALLOC, 0, 0), 1'b0);     // slot 1
    send_request(make_req(rrts_pkg::MODE_RUN, 31, 0), 1'b0);      // zero priority
    send_request(make_req(rrts_pkg::MODE_RUN, 0, 255), 1'b0);
    send_request(make_req(rrts_pkg::MODE_RUN, 31, 1), 1'b0);      // free slot run directly
    send_request(make_req(rrts_pkg::MODE_RUN, 5, 128), 1'b0);
    send_request(make_req(rrts_pkg::MODE_RUN, 0, 7), 1'b0);       // already on the list
    send_request(make_req(rrts_pkg::MODE_SWITCH, 31, 255), 1'b0);
    send_request(make_req(rrts_pkg::MODE_SWITCH, 0, 0), 1'b0);
    send_request(make_req(rrts_pkg::MODE_SWITCH, 0, 0), 1'b0);    // wrap to head
    send_request(make_req(rrts_pkg::MODE_SLEEP, 5, 0), 1'b0);     // behind current
    send_request(make_req(rrts_pkg::MODE_SWITCH, 0, 0), 1'b0);
    send_request(make_req(rrts_pkg::MODE_SLEEP, 0, 0), 1'b0);     // ahead of current
    send_request(make_req(rrts_pkg::MODE_RUN, 5, 200), 1'b0);
    send_request(make_req(rrts_pkg::MODE_SWITCH, 0, 0), 1'b0);
    send_request(make_req(rrts_pkg::MODE_SLEEP, 5, 0), 1'b0);     // current, last entry
    send_request(make_req(rrts_pkg::MODE_SWITCH, 0, 0), 1'b0);    // single entry, no change
    send_request(make_req(rrts_pkg::MODE_RUN, 3, 9), 1'b0);
    send_request(make_req(rrts_pkg::MODE_SLEEP, 31, 0), 1'b0);    // current, not last
    send_request(make_req(rrts_pkg::MODE_SLEEP, 3, 0), 1'b0);     // list emptied
    send_request(make_req(rrts_pkg::MODE_SLEEP, 3, 0), 1'b0);     // now only allocated
    send_request(make_req(rrts_pkg::MODE_ALLOC, 0, 0), 1'b0);     // slot 2

    // Mixed traffic; idling switches on and off in stretches.
    for (int n = 0; n < 240; n++) begin
      if (n % 32 == 0) gaps_on = ($urandom_range(0, 2) != 0);
      send_request(random_req(25), gaps_on);
    end

    drain_results();

    // Allocate past the end of the pool so the no-free case is certain.
    repeat (34) send_request(make_req(rrts_pkg::MODE_ALLOC, $urandom_range(0, 31),
                                      $urandom_range(0, 255)), 1'b1);

    // Sleep-heavy traffic, emptying the run list now and then.
    for (int n = 0; n < 200; n++) begin
      if (n % 32 == 0) gaps_on = ($urandom_range(0, 2) != 0);
      if (n % 60 == 59) begin
        for (int k = 0; k < rrts_pkg::NUM_SLOTS + 2 && sb.run_cnt != 0; k++)
          send_request(make_req(rrts_pkg::MODE_SLEEP, sb.pick_runnable(), 0), gaps_on);
      end
      send_request(random_req(40), gaps_on);
    end

    // Closing stretch at full rate.
    for (int n = 0; n < 120; n++) send_request(random_req(25), 1'b0);

    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end
endmodule
